### design/ffl_pkg.sv
// Shared types and constants for the first-fit free list.
`default_nettype none

package ffl_pkg;

    // Default sizing
    localparam int DEF_NUM_SLOTS = 64;
    localparam int DEF_SIZE_BITS = 24;

    // Fixed port widths
    localparam int CMD_W      = 2;
    localparam int IDX_OUT_W  = 6;
    localparam int LINK_OUT_W = 7;
    localparam int SIZE_IN_W  = 24;

    // Broadcast write ports; a higher port number wins on the same slot and field
    localparam int WR_PORTS = 3;
    localparam int WP_A     = 0;
    localparam int WP_B     = 1;
    localparam int WP_C     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_UNLINK = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    // Flags of the token that runs down the cell row
    typedef struct packed {
        logic valid;
        logic is_find;
        logic done;
    } tok_ctl_t;

    // Flags of one broadcast write port
    typedef struct packed {
        logic en;
        logic set_next;
        logic set_prev;
        logic set_size;
    } wr_ctl_t;

endpackage

`default_nettype wire

### design/ffl_cell.sv
// One slot cell: holds a slot's links and size, and forwards the search token.
`default_nettype none

module ffl_cell #(
    parameter int NUM_SLOTS = ffl_pkg::DEF_NUM_SLOTS,
    parameter int SIZE_BITS = ffl_pkg::DEF_SIZE_BITS,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = $clog2(NUM_SLOTS),
    localparam int LINK_W   = $clog2(NUM_SLOTS + 1),
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // broadcast writes
    input  ffl_pkg::wr_ctl_t      wr_ctl  [ffl_pkg::WR_PORTS],
    input  logic [IDX_W-1:0]      wr_addr [ffl_pkg::WR_PORTS],
    input  logic [LINK_W-1:0]     wr_next [ffl_pkg::WR_PORTS],
    input  logic [LINK_W-1:0]     wr_prev [ffl_pkg::WR_PORTS],
    input  logic [SIZE_BITS-1:0]  wr_size,
    input  logic [SIZE_BITS-1:0]  want,
    // token from the previous cell
    input  ffl_pkg::tok_ctl_t     in_ctl,
    input  logic [LINK_W-1:0]     in_cur,
    input  logic [CNT_W-1:0]      in_steps,
    input  logic [LINK_W-1:0]     in_rdn,
    input  logic [LINK_W-1:0]     in_rdp,
    // token to the next cell
    output ffl_pkg::tok_ctl_t     out_ctl,
    output logic [LINK_W-1:0]     out_cur,
    output logic [CNT_W-1:0]      out_steps,
    output logic [LINK_W-1:0]     out_rdn,
    output logic [LINK_W-1:0]     out_rdp
);

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);
    localparam logic [LINK_W-1:0] MY_LINK   = LINK_W'(CELL_IDX);
    localparam logic [IDX_W-1:0]  MY_IDX    = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0]  STEP_MAX  = CNT_W'(NUM_SLOTS);

    logic [LINK_W-1:0]    next_link_reg, next_link_next;
    logic [LINK_W-1:0]    prev_link_reg, prev_link_next;
    logic [SIZE_BITS-1:0] slot_size_reg, slot_size_next;

    ffl_pkg::tok_ctl_t    tctl_reg, tctl_next;
    logic [LINK_W-1:0]    tcur_reg, tcur_next;
    logic [CNT_W-1:0]     tsteps_reg, tsteps_next;
    logic [LINK_W-1:0]    trdn_reg, trdn_next;
    logic [LINK_W-1:0]    trdp_reg, trdp_next;

    logic hit;

    // writes, later port wins
    always_comb
    begin
        next_link_next = next_link_reg;
        prev_link_next = prev_link_reg;
        slot_size_next = slot_size_reg;
        for (int k = 0; k < ffl_pkg::WR_PORTS; k++)
        begin
            if (wr_ctl[k].en && (wr_addr[k] == MY_IDX))
            begin
                if (wr_ctl[k].set_next)
                begin
                    next_link_next = wr_next[k];
                end
                if (wr_ctl[k].set_prev)
                begin
                    prev_link_next = wr_prev[k];
                end
                if (wr_ctl[k].set_size)
                begin
                    slot_size_next = wr_size;
                end
            end
        end
    end

    // token handling: act only when the token points at this slot
    assign hit = in_ctl.valid && !in_ctl.done && (in_cur == MY_LINK);

    always_comb
    begin
        tctl_next   = in_ctl;
        tcur_next   = in_cur;
        tsteps_next = in_steps;
        trdn_next   = in_rdn;
        trdp_next   = in_rdp;
        if (hit)
        begin
            if (in_ctl.is_find)
            begin
                if (in_steps < STEP_MAX)
                begin
                    if (slot_size_reg >= want)
                    begin
                        tctl_next.done = 1'b1;
                    end
                    else
                    begin
                        tcur_next   = next_link_reg;
                        tsteps_next = in_steps + CNT_W'(1);
                    end
                end
            end
            else
            begin
                trdn_next      = next_link_reg;
                trdp_next      = prev_link_reg;
                tctl_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_link_reg <= LINK_NONE;
            prev_link_reg <= LINK_NONE;
            tctl_reg      <= '0;
        end
        else
        begin
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
            tctl_reg      <= tctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_size_reg <= slot_size_next;
        tcur_reg      <= tcur_next;
        tsteps_reg    <= tsteps_next;
        trdn_reg      <= trdn_next;
        trdp_reg      <= trdp_next;
    end

    assign out_ctl   = tctl_reg;
    assign out_cur   = tcur_reg;
    assign out_steps = tsteps_reg;
    assign out_rdn   = trdn_reg;
    assign out_rdp   = trdp_reg;

endmodule

`default_nettype wire

### design/first_fit_free_list_top.sv
// Top level of the first-fit free list: command sequencer and the row of slot cells.
//
//  Channel   | Signals                                              | Transfer
//  ----------+------------------------------------------------------+---------------------------
//  command   | start, busy, cmd, block_index, block_size,           | start high and busy low
//            | wanted_size                                          |
//  result    | done, found, found_index, next_index, prev_index     | done high for one cycle
//
//  Each slot lives in its own cell. Reads travel as a token down the row of
//  NUM_SLOTS registered cells, one cell per cycle; the token leaving the last
//  cell returns to the sequencer. Writes are broadcast to all cells at once.
//  Steps per transaction: push goes straight to the write state; a links query
//    takes one pass over the row; unlink takes one pass, then the write state;
//    find takes L passes over the row, 1 <= L <= NUM_SLOTS
//    (a pass follows every forward link it meets; a backward link costs a pass).
//  An unlink or query of an out-of-range slot skips the row and goes straight to the write state.
//  Reset empties the list and sets every link to none at once; no clearing pass.
//  The result is shown for exactly one cycle; the receiver cannot stall it, and a
//  new command may be accepted in that same cycle.
`default_nettype none

module first_fit_free_list_top #(
    parameter int NUM_SLOTS = ffl_pkg::DEF_NUM_SLOTS,
    parameter int SIZE_BITS = ffl_pkg::DEF_SIZE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ffl_pkg::CMD_W-1:0]        cmd,
    input  logic [ffl_pkg::IDX_OUT_W-1:0]    block_index,
    input  logic [ffl_pkg::SIZE_IN_W-1:0]    block_size,
    input  logic [ffl_pkg::SIZE_IN_W-1:0]    wanted_size,
    output logic                             done,
    output logic                             found,
    output logic [ffl_pkg::IDX_OUT_W-1:0]    found_index,
    output logic [ffl_pkg::LINK_OUT_W-1:0]   next_index,
    output logic [ffl_pkg::LINK_OUT_W-1:0]   prev_index
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int IW_W   = IDX_W + ffl_pkg::IDX_OUT_W;
    localparam int SW_W   = SIZE_BITS + ffl_pkg::SIZE_IN_W;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0]  STEP_MAX  = CNT_W'(NUM_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LAP   = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    // Width fitting toward the fixed result ports
    function automatic logic [ffl_pkg::LINK_OUT_W-1:0] link_out(input logic [LINK_W-1:0] v);
        logic [LINK_W+ffl_pkg::LINK_OUT_W-1:0] w;
        w = {{ffl_pkg::LINK_OUT_W{1'b0}}, v};
        return w[ffl_pkg::LINK_OUT_W-1:0];
    endfunction

    function automatic logic [ffl_pkg::IDX_OUT_W-1:0] idx_out(input logic [LINK_W-1:0] v);
        logic [LINK_W+ffl_pkg::IDX_OUT_W-1:0] w;
        w = {{ffl_pkg::IDX_OUT_W{1'b0}}, v};
        return w[ffl_pkg::IDX_OUT_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Input fitting
    // ---------------------------------------------------------------------
    logic [IW_W-1:0]      bi_wide;
    logic                 bi_ok;
    logic [IDX_W-1:0]     bi;
    logic [SW_W-1:0]      bs_wide;
    logic [SW_W-1:0]      ws_wide;
    ffl_pkg::cmd_t        cmd_in;
    logic                 accept;

    assign bi_wide = {{IDX_W{1'b0}}, block_index};
    assign bi_ok   = bi_wide < IW_W'(NUM_SLOTS);
    assign bi      = bi_wide[IDX_W-1:0];
    assign bs_wide = {{SIZE_BITS{1'b0}}, block_size};
    assign ws_wide = {{SIZE_BITS{1'b0}}, wanted_size};
    assign cmd_in  = ffl_pkg::cmd_t'(cmd);

    // ---------------------------------------------------------------------
    // Sequencer state and request registers
    // ---------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    ffl_pkg::cmd_t        cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 idx_ok_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] want_reg;
    logic [SIZE_BITS-1:0] want_cell;
    logic [LINK_W-1:0]    plink_reg;
    logic [LINK_W-1:0]    nlink_reg;
    logic                 lat_pn;

    // result registers
    logic                              done_reg, done_next;
    logic                              found_reg, found_next;
    logic [ffl_pkg::IDX_OUT_W-1:0]     fidx_reg, fidx_next;
    logic [ffl_pkg::LINK_OUT_W-1:0]    nidx_reg, nidx_next;
    logic [ffl_pkg::LINK_OUT_W-1:0]    pidx_reg, pidx_next;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // cell 0 sees the token in the accept cycle, before want_reg is loaded
    assign want_cell = accept ? ws_wide[SIZE_BITS-1:0] : want_reg;

    // ---------------------------------------------------------------------
    // Token chain: entry 0 is injected here, entry NUM_SLOTS leaves the last cell
    // ---------------------------------------------------------------------
    ffl_pkg::tok_ctl_t    ch_ctl   [NUM_SLOTS+1];
    logic [LINK_W-1:0]    ch_cur   [NUM_SLOTS+1];
    logic [CNT_W-1:0]     ch_steps [NUM_SLOTS+1];
    logic [LINK_W-1:0]    ch_rdn   [NUM_SLOTS+1];
    logic [LINK_W-1:0]    ch_rdp   [NUM_SLOTS+1];

    ffl_pkg::tok_ctl_t    inj_ctl;
    logic [LINK_W-1:0]    inj_cur;
    logic [CNT_W-1:0]     inj_steps;

    ffl_pkg::tok_ctl_t    t_ctl;
    logic [LINK_W-1:0]    t_cur;
    logic [CNT_W-1:0]     t_steps;

    assign ch_ctl[0]   = inj_ctl;
    assign ch_cur[0]   = inj_cur;
    assign ch_steps[0] = inj_steps;
    assign ch_rdn[0]   = LINK_NONE;
    assign ch_rdp[0]   = LINK_NONE;

    assign t_ctl   = ch_ctl[NUM_SLOTS];
    assign t_cur   = ch_cur[NUM_SLOTS];
    assign t_steps = ch_steps[NUM_SLOTS];

    // ---------------------------------------------------------------------
    // Broadcast write bus
    // ---------------------------------------------------------------------
    ffl_pkg::wr_ctl_t     wctl  [ffl_pkg::WR_PORTS];
    logic [IDX_W-1:0]     waddr [ffl_pkg::WR_PORTS];
    logic [LINK_W-1:0]    wnext [ffl_pkg::WR_PORTS];
    logic [LINK_W-1:0]    wprev [ffl_pkg::WR_PORTS];
    logic                 do_write;
    logic                 p_ok;
    logic                 n_ok;
    logic                 h_ok;

    assign do_write = (state_reg == ST_WRITE) && idx_ok_reg;
    assign p_ok     = plink_reg < LINK_NONE;
    assign n_ok     = nlink_reg < LINK_NONE;
    assign h_ok     = head_reg < LINK_NONE;

    // Push:   A sets the new slot (next = head, prev = none, size),
    //         B points the old head back at the new slot.
    // Unlink: A bypasses forward, B bypasses backward, C clears the slot last.
    always_comb
    begin
        for (int k = 0; k < ffl_pkg::WR_PORTS; k++)
        begin
            wctl[k]  = '0;
            waddr[k] = idx_reg;
            wnext[k] = LINK_NONE;
            wprev[k] = LINK_NONE;
        end
        head_next = head_reg;
        if (do_write)
        begin
            case (cmd_reg)
                ffl_pkg::CMD_PUSH:
                begin
                    wctl[ffl_pkg::WP_A]  = '{en: 1'b1, set_next: 1'b1,
                                             set_prev: 1'b1, set_size: 1'b1};
                    waddr[ffl_pkg::WP_A] = idx_reg;
                    wnext[ffl_pkg::WP_A] = head_reg;
                    wprev[ffl_pkg::WP_A] = LINK_NONE;
                    wctl[ffl_pkg::WP_B]  = '{en: h_ok, set_next: 1'b0,
                                             set_prev: 1'b1, set_size: 1'b0};
                    waddr[ffl_pkg::WP_B] = head_reg[IDX_W-1:0];
                    wprev[ffl_pkg::WP_B] = LINK_W'(idx_reg);
                    head_next            = LINK_W'(idx_reg);
                end
                ffl_pkg::CMD_UNLINK:
                begin
                    wctl[ffl_pkg::WP_A]  = '{en: p_ok, set_next: 1'b1,
                                             set_prev: 1'b0, set_size: 1'b0};
                    waddr[ffl_pkg::WP_A] = plink_reg[IDX_W-1:0];
                    wnext[ffl_pkg::WP_A] = nlink_reg;
                    wctl[ffl_pkg::WP_B]  = '{en: n_ok, set_next: 1'b0,
                                             set_prev: 1'b1, set_size: 1'b0};
                    waddr[ffl_pkg::WP_B] = nlink_reg[IDX_W-1:0];
                    wprev[ffl_pkg::WP_B] = plink_reg;
                    wctl[ffl_pkg::WP_C]  = '{en: 1'b1, set_next: 1'b1,
                                             set_prev: 1'b1, set_size: 1'b0};
                    waddr[ffl_pkg::WP_C] = idx_reg;
                    if (!p_ok)
                    begin
                        head_next = nlink_reg;
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        inj_ctl    = '0;
        inj_cur    = LINK_NONE;
        inj_steps  = '0;
        lat_pn     = 1'b0;
        done_next  = 1'b0;
        found_next = 1'b0;
        fidx_next  = '0;
        nidx_next  = link_out(LINK_NONE);
        pidx_next  = link_out(LINK_NONE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        ffl_pkg::CMD_PUSH:
                        begin
                            state_next = ST_WRITE;
                        end
                        ffl_pkg::CMD_UNLINK, ffl_pkg::CMD_QUERY:
                        begin
                            if (bi_ok)
                            begin
                                inj_ctl    = '{valid: 1'b1, is_find: 1'b0, done: 1'b0};
                                inj_cur    = LINK_W'(bi);
                                state_next = ST_LAP;
                            end
                            else
                            begin
                                state_next = ST_WRITE;
                            end
                        end
                        ffl_pkg::CMD_FIND:
                        begin
                            inj_ctl    = '{valid: 1'b1, is_find: 1'b1, done: 1'b0};
                            inj_cur    = head_reg;
                            state_next = ST_LAP;
                        end
                    endcase
                end
            end
            ST_LAP:
            begin
                if (t_ctl.valid)
                begin
                    case (cmd_reg)
                        ffl_pkg::CMD_UNLINK:
                        begin
                            lat_pn     = 1'b1;
                            state_next = ST_WRITE;
                        end
                        ffl_pkg::CMD_QUERY:
                        begin
                            done_next  = 1'b1;
                            nidx_next  = link_out(ch_rdn[NUM_SLOTS]);
                            pidx_next  = link_out(ch_rdp[NUM_SLOTS]);
                            state_next = ST_IDLE;
                        end
                        ffl_pkg::CMD_FIND:
                        begin
                            if (t_ctl.done)
                            begin
                                done_next  = 1'b1;
                                found_next = 1'b1;
                                fidx_next  = idx_out(t_cur);
                                state_next = ST_IDLE;
                            end
                            else if ((t_cur < LINK_NONE) && (t_steps < STEP_MAX))
                            begin
                                // walk continues on another pass over the row
                                inj_ctl   = '{valid: 1'b1, is_find: 1'b1, done: 1'b0};
                                inj_cur   = t_cur;
                                inj_steps = t_steps;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= LINK_NONE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_in;
            idx_reg    <= bi;
            idx_ok_reg <= bi_ok;
            size_reg   <= bs_wide[SIZE_BITS-1:0];
            want_reg   <= ws_wide[SIZE_BITS-1:0];
        end
        if (lat_pn)
        begin
            plink_reg <= ch_rdp[NUM_SLOTS];
            nlink_reg <= ch_rdn[NUM_SLOTS];
        end
        if (done_next)
        begin
            found_reg <= found_next;
            fidx_reg  <= fidx_next;
            nidx_reg  <= nidx_next;
            pidx_reg  <= pidx_next;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign next_index  = nidx_reg;
    assign prev_index  = pidx_reg;

    // ---------------------------------------------------------------------
    // Row of slot cells
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        ffl_cell #(
            .NUM_SLOTS (NUM_SLOTS),
            .SIZE_BITS (SIZE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_ctl    (wctl),
            .wr_addr   (waddr),
            .wr_next   (wnext),
            .wr_prev   (wprev),
            .wr_size   (size_reg),
            .want      (want_cell),
            .in_ctl    (ch_ctl[g]),
            .in_cur    (ch_cur[g]),
            .in_steps  (ch_steps[g]),
            .in_rdn    (ch_rdn[g]),
            .in_rdp    (ch_rdp[g]),
            .out_ctl   (ch_ctl[g+1]),
            .out_cur   (ch_cur[g+1]),
            .out_steps (ch_steps[g+1]),
            .out_rdn   (ch_rdn[g+1]),
            .out_rdp   (ch_rdp[g+1])
        );
    end

endmodule

`default_nettype wire
